>>> sv/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

   localparam int ValueW = 64;
   localparam int ModeW  = 2;
   localparam int RadixW = 5;
   localparam int CharW  = 8;
   localparam int CountW = 7;
   localparam int DigitW = 4;
   localparam int PfxW   = 3;

   localparam logic [RadixW-1:0] RadixMin = 5'd2;
   localparam logic [RadixW-1:0] RadixMax = 5'd16;
   localparam logic [RadixW-1:0] RadixDec = 5'd10;
   localparam logic [RadixW-1:0] RadixHex = 5'd16;

   localparam logic [CharW-1:0] CharZero   = 8'h30;
   localparam logic [CharW-1:0] CharUpperA = 8'h41;
   localparam logic [CharW-1:0] CharLowerA = 8'h61;
   localparam logic [CharW-1:0] CharMinus  = 8'h2d;
   localparam logic [CharW-1:0] CharX      = 8'h78;
   localparam logic [CharW-1:0] CharOpen   = 8'h28;
   localparam logic [CharW-1:0] CharN      = 8'h6e;
   localparam logic [CharW-1:0] CharI      = 8'h69;
   localparam logic [CharW-1:0] CharL      = 8'h6c;
   localparam logic [CharW-1:0] CharClose  = 8'h29;

   typedef enum logic [ModeW-1:0] {
      MODE_DEC   = 2'd0,
      MODE_RADIX = 2'd1,
      MODE_PTR   = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PFX_NONE  = 2'd0,
      PFX_MINUS = 2'd1,
      PFX_HEX   = 2'd2,
      PFX_NIL   = 2'd3
   } prefix_type;

   function automatic logic [CharW-1:0] digit_char(logic [DigitW-1:0] d, logic upper);
      logic [CharW-1:0] base;
      base = upper ? CharUpperA : CharLowerA;
      if (d < DigitW'(10)) begin
         digit_char = CharZero + CharW'(d);
      end else begin
         digit_char = base + CharW'(d) - CharW'(10);
      end
   endfunction

   function automatic logic [PfxW-1:0] prefix_len(prefix_type kind);
      case (kind)
         PFX_MINUS: prefix_len = 3'd1;
         PFX_HEX:   prefix_len = 3'd2;
         PFX_NIL:   prefix_len = 3'd5;
         default:   prefix_len = 3'd0;
      endcase
   endfunction

   function automatic logic [CharW-1:0] prefix_char(prefix_type kind, logic [PfxW-1:0] pos);
      case (kind)
         PFX_MINUS: prefix_char = CharMinus;
         PFX_HEX:   prefix_char = (pos == 3'd0) ? CharZero : CharX;
         PFX_NIL: begin
            case (pos)
               3'd0:    prefix_char = CharOpen;
               3'd1:    prefix_char = CharN;
               3'd2:    prefix_char = CharI;
               3'd3:    prefix_char = CharL;
               default: prefix_char = CharClose;
            endcase
         end
         default:   prefix_char = CharZero;
      endcase
   endfunction

endpackage

`default_nettype wire

>>> sv/itoa_ifs.sv
`default_nettype none

interface itoa_req_if;
   import itoa_pkg::*;

   logic                valid;
   logic                ready;
   logic [ModeW-1:0]    mode;
   logic [ValueW-1:0]   value;
   logic [RadixW-1:0]   radix;
   logic                upper_case;

   modport source (output valid, mode, value, radix, upper_case, input ready);
   modport sink   (input valid, mode, value, radix, upper_case, output ready);
endinterface

interface itoa_rsp_if;
   import itoa_pkg::*;

   logic                valid;
   logic                ready;
   logic [CharW-1:0]    ascii_char;
   logic                last;
   logic [CountW-1:0]   char_count;

   modport source (output valid, ascii_char, last, char_count, input ready);
   modport sink   (input valid, ascii_char, last, char_count, output ready);
endinterface

`default_nettype wire

>>> sv/integer_to_ascii_formatter.sv
`default_nettype none

// channel   dir   handshake       beat
// req_if    in    valid/ready     mode, value, radix, upper_case
// rsp_if    out   valid/ready     ascii_char, last, char_count
//
// one item at a time; req_if.ready is high only while idle
// each digit is worked out in the shared 4-bit-per-cycle divider
// each character then needs a digit memory read, then a beat, which waits out any rsp stall
// synchronous reset clears the sequencer only; no clearing pass on the digit memory
// an unused mode code is taken and dropped with no beats

module integer_to_ascii_formatter #(
   parameter int VALUE_WIDTH = 64
) (
   input  logic          clock,
   input  logic          reset,
   itoa_req_if.sink      req_if,
   itoa_rsp_if.source    rsp_if
);
   import itoa_pkg::*;

   localparam int DivW          = ((VALUE_WIDTH + DigitW - 1) / DigitW) * DigitW;
   localparam int StepsPerDigit = DivW / DigitW;
   localparam int StepW         = $clog2(StepsPerDigit);
   localparam int AddrW         = $clog2(VALUE_WIDTH);
   localparam logic [StepW-1:0] LastStep = StepW'(StepsPerDigit - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [DivW-1:0]     div_ff, div_in;
   logic [DigitW-1:0]   rem_ff, rem_in;
   logic [StepW-1:0]    step_ff, step_in;
   logic [RadixW-1:0]   radix_ff, radix_in;
   logic                upper_ff, upper_in;
   prefix_type          kind_ff, kind_in;
   logic [CountW-1:0]   ndig_ff, ndig_in;
   logic [CountW-1:0]   pos_ff, pos_in;
   logic [DigitW-1:0]   rd_data_ff;
   logic [DigitW-1:0]   mem [VALUE_WIDTH];

   logic                req_fire;
   logic                wr_en;
   logic [DivW-1:0]     div_q;
   logic [DigitW-1:0]   rem_q;
   logic [31:0]         w32;
   logic                neg;
   logic [31:0]         mag32;
   logic [VALUE_WIDTH-1:0] masked;
   logic [RadixW-1:0]   radix_sat;
   logic [PfxW-1:0]     pfx_len;
   logic [CountW-1:0]   total;
   logic                is_pfx;
   logic [CountW-1:0]   digit_idx;
   logic [CountW-1:0]   dig_addr;
   logic [AddrW-1:0]    rd_addr;
   logic                is_last;

   // shared divider: four restoring steps per cycle
   always_comb begin
      logic [DigitW:0] x;
      rem_q = rem_ff;
      div_q = div_ff;
      for (int k = 0; k < DigitW; k++) begin
         x = {rem_q, div_q[DivW-1]};
         if (x >= radix_ff) begin
            rem_q = DigitW'(x - radix_ff);
            div_q = {div_q[DivW-2:0], 1'b1};
         end else begin
            rem_q = x[DigitW-1:0];
            div_q = {div_q[DivW-2:0], 1'b0};
         end
      end
   end

   assign req_fire = req_if.valid && req_if.ready;
   assign w32      = req_if.value[31:0];
   assign neg      = w32[31];
   assign mag32    = neg ? (~w32 + 32'd1) : w32;
   assign masked   = req_if.value[VALUE_WIDTH-1:0];

   always_comb begin
      if (req_if.radix < RadixMin) begin
         radix_sat = RadixMin;
      end else if (req_if.radix > RadixMax) begin
         radix_sat = RadixMax;
      end else begin
         radix_sat = req_if.radix;
      end
   end

   // character position decode
   assign pfx_len   = prefix_len(kind_ff);
   assign total     = CountW'(pfx_len) + ndig_ff;
   assign is_pfx    = pos_ff < CountW'(pfx_len);
   assign digit_idx = pos_ff - CountW'(pfx_len);
   assign dig_addr  = ndig_ff - CountW'(1) - digit_idx;
   assign rd_addr   = dig_addr[AddrW-1:0];
   assign is_last   = pos_ff == (total - CountW'(1));

   always_comb begin
      state_in = state_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      radix_in = radix_ff;
      upper_in = upper_ff;
      kind_in  = kind_ff;
      ndig_in  = ndig_ff;
      pos_in   = pos_ff;
      wr_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in   = '0;
               ndig_in  = '0;
               step_in  = '0;
               rem_in   = '0;
               upper_in = 1'b0;
               radix_in = RadixHex;
               kind_in  = PFX_NONE;
               div_in   = DivW'(masked);
               case (mode_type'(req_if.mode))
                  MODE_DEC: begin
                     div_in   = DivW'(mag32);
                     radix_in = RadixDec;
                     kind_in  = neg ? PFX_MINUS : PFX_NONE;
                     state_in = ST_DIV;
                  end
                  MODE_RADIX: begin
                     radix_in = radix_sat;
                     upper_in = req_if.upper_case;
                     state_in = ST_DIV;
                  end
                  MODE_PTR: begin
                     if (masked == '0) begin
                        kind_in  = PFX_NIL;
                        state_in = ST_FETCH;
                     end else begin
                        kind_in  = PFX_HEX;
                        state_in = ST_DIV;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            div_in  = div_q;
            rem_in  = rem_q;
            step_in = step_ff + StepW'(1);
            if (step_ff == LastStep) begin
               wr_en   = 1'b1;
               rem_in  = '0;
               step_in = '0;
               ndig_in = ndig_ff + CountW'(1);
               if (div_q == '0) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_if.ready) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff + CountW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      radix_ff <= radix_in;
      upper_ff <= upper_in;
      kind_ff  <= kind_in;
      ndig_ff  <= ndig_in;
      pos_ff   <= pos_in;
   end

   // digit memory, least significant digit first
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ndig_ff[AddrW-1:0]] <= rem_q;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_if.ready      = state_ff == ST_IDLE;
   assign rsp_if.valid      = state_ff == ST_SEND;
   assign rsp_if.ascii_char = is_pfx ? prefix_char(kind_ff, pos_ff[PfxW-1:0])
                                     : digit_char(rd_data_ff, upper_ff);
   assign rsp_if.last       = is_last;
   assign rsp_if.char_count = is_last ? total : '0;

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.mode != MODE_NONE) |=> !req_if.ready)
      else $error("accepted item did not leave idle");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("beat offered while idle");

   a_count_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.last) |-> (rsp_if.char_count != '0))
      else $error("final beat with zero count");

   a_digits_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (ndig_ff <= CountW'(VALUE_WIDTH)))
      else $error("digit count overflow");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_ff == LastStep && div_q == '0) |=> (state_ff == ST_FETCH))
      else $error("division did not finish on zero quotient");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import itoa_pkg::*;

   localparam int MaxGap      = 14;
   localparam int RandomItems = 145;
   localparam int ReportLimit = 10;
   localparam int DrainCycles = 1200;
   localparam int CycleLimit  = 1500000;

   typedef struct packed {
      logic [CharW-1:0]  ascii_char;
      logic              last;
      logic [CountW-1:0] char_count;
   } char_beat_type;

   logic clock = 1'b0;
   logic reset;

   itoa_req_if req_if ();
   itoa_rsp_if rsp_if ();

   integer_to_ascii_formatter uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   char_beat_type pending_chars[$];
   int            fail_count;
   int            cycle_count;
   bit            req_steady;
   bit            rsp_steady;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [CharW-1:0] digit_code(logic [DigitW-1:0] d, logic upper);
      if (d < 4'd10) begin
         return CharZero + CharW'(d);
      end
      return (upper ? CharUpperA : CharLowerA) + CharW'(d - 4'd10);
   endfunction

   function automatic void predict_text(mode_type mode, logic [ValueW-1:0] value,
                                        logic [RadixW-1:0] radix, logic upper);
      logic [CharW-1:0]  text[$];
      logic [CharW-1:0]  rev[$];
      logic [ValueW-1:0] mag;
      logic [ValueW-1:0] base;
      logic [31:0]       word;
      logic              caps;
      bit                digits;
      char_beat_type     beat;
      digits = 1'b1;
      caps   = 1'b0;
      mag    = '0;
      base   = ValueW'(RadixDec);
      case (mode)
         MODE_DEC: begin
            word = value[31:0];
            if (word[31]) begin
               text.push_back(CharMinus);
               word = ~word + 32'd1;
            end
            mag = ValueW'(word);
         end
         MODE_RADIX: begin
            mag  = value;
            caps = upper;
            if (radix < RadixMin) begin
               base = ValueW'(RadixMin);
            end else if (radix > RadixMax) begin
               base = ValueW'(RadixMax);
            end else begin
               base = ValueW'(radix);
            end
         end
         MODE_PTR: begin
            mag  = value;
            base = ValueW'(RadixHex);
            if (value == '0) begin
               text    = '{CharOpen, CharN, CharI, CharL, CharClose};
               digits  = 1'b0;
            end else begin
               text.push_back(CharZero);
               text.push_back(CharX);
            end
         end
         default: return;
      endcase
      if (digits) begin
         do begin
            rev.push_front(digit_code(DigitW'(mag % base), caps));
            mag = mag / base;
         end while (mag != '0);
         foreach (rev[i]) text.push_back(rev[i]);
      end
      foreach (text[i]) begin
         beat.ascii_char = text[i];
         beat.last       = (i == text.size() - 1);
         beat.char_count = beat.last ? CountW'(text.size()) : '0;
         pending_chars.push_back(beat);
      end
   endfunction

   task automatic send_item(mode_type mode, logic [ValueW-1:0] value,
                            logic [RadixW-1:0] radix, logic upper);
      int gap;
      if ($urandom_range(0, 14) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.mode       <= mode;
      req_if.value      <= value;
      req_if.radix      <= radix;
      req_if.upper_case <= upper;
      do @(posedge clock); while (!req_if.ready);
      predict_text(mode, value, radix, upper);
   endtask

   function automatic logic [ValueW-1:0] random_value();
      logic [ValueW-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = ValueW'($urandom_range(0, 1000));
         1: v = ValueW'($urandom);
         2: v = v >> $urandom_range(0, ValueW - 1);
         3: v = ValueW'(1) << $urandom_range(0, ValueW - 1);
         4: v = $urandom_range(0, 1) ? '1 : '0;
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_signed_decimal();
      send_item(MODE_DEC, 64'd0, 5'd10, 1'b0);
      send_item(MODE_DEC, 64'd1, 5'd10, 1'b0);
      send_item(MODE_DEC, 64'h0000_0000_ffff_ffff, 5'd3, 1'b1);
      send_item(MODE_DEC, 64'h0000_0000_7fff_ffff, 5'd0, 1'b0);
      send_item(MODE_DEC, 64'h0000_0000_8000_0000, 5'd31, 1'b1);
      send_item(MODE_DEC, 64'hffff_ffff_0000_0123, 5'd16, 1'b0);
      send_item(MODE_DEC, 64'h1234_5678_8000_0001, 5'd10, 1'b0);
   endtask

   task automatic test_radix_output();
      send_item(MODE_RADIX, 64'd0, 5'd10, 1'b0);
      send_item(MODE_RADIX, '1, 5'd2, 1'b0);
      send_item(MODE_RADIX, '1, 5'd16, 1'b1);
      send_item(MODE_RADIX, 64'hfedc_ba98_7654_3210, 5'd16, 1'b0);
      send_item(MODE_RADIX, 64'hfedc_ba98_7654_3210, 5'd16, 1'b1);
      send_item(MODE_RADIX, 64'd255, 5'd0, 1'b0);
      send_item(MODE_RADIX, 64'd255, 5'd1, 1'b0);
      send_item(MODE_RADIX, 64'd48879, 5'd17, 1'b1);
      send_item(MODE_RADIX, 64'd48879, 5'd31, 1'b0);
      send_item(MODE_RADIX, '1, 5'd8, 1'b0);
      send_item(MODE_RADIX, '1, 5'd10, 1'b0);
      send_item(MODE_RADIX, 64'd12345, 5'd3, 1'b1);
   endtask

   task automatic test_pointer_output();
      send_item(MODE_PTR, 64'd0, 5'd10, 1'b1);
      send_item(MODE_PTR, 64'd1, 5'd10, 1'b1);
      send_item(MODE_PTR, '1, 5'd2, 1'b1);
      send_item(MODE_PTR, 64'h0000_0000_dead_beef, 5'd16, 1'b0);
   endtask

   task automatic test_unused_mode();
      send_item(MODE_NONE, 64'h0123_4567_89ab_cdef, 5'd16, 1'b1);
      send_item(MODE_DEC, 64'h0000_0000_ffff_ff85, 5'd10, 1'b0);
   endtask

   task automatic test_random_items();
      int               sent;
      int               pick;
      mode_type         mode;
      logic [RadixW-1:0] radix;
      sent = 0;
      while (sent < RandomItems) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            mode = MODE_DEC;
         end else if (pick < 7) begin
            mode = MODE_RADIX;
         end else if (pick < 9) begin
            mode = MODE_PTR;
         end else begin
            mode = MODE_NONE;
         end
         if ($urandom_range(0, 3) == 0) begin
            radix = RadixW'($urandom_range(0, 31));
         end else begin
            radix = RadixW'($urandom_range(2, 16));
         end
         send_item(mode, random_value(), radix, 1'($urandom_range(0, 1)));
         sent++;
      end
   endtask

   initial begin
      char_beat_type want;
      int            stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if ($urandom_range(0, 49) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(0, MaxGap);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (pending_chars.size() == 0) begin
            fail_count++;
            if (fail_count <= ReportLimit) begin
               $display("unexpected beat: char %h last %b count %0d",
                        rsp_if.ascii_char, rsp_if.last, rsp_if.char_count);
            end
         end else begin
            want = pending_chars.pop_front();
            if (rsp_if.ascii_char !== want.ascii_char || rsp_if.last !== want.last ||
                rsp_if.char_count !== want.char_count) begin
               fail_count++;
               if (fail_count <= ReportLimit) begin
                  $display("mismatch: expected char %h last %b count %0d, got %h %b %0d",
                           want.ascii_char, want.last, want.char_count,
                           rsp_if.ascii_char, rsp_if.last, rsp_if.char_count);
               end
            end
         end
      end
   end

   initial begin
      req_steady        = 1'b0;
      reset            <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.mode       <= MODE_DEC;
      req_if.value      <= '0;
      req_if.radix      <= RadixDec;
      req_if.upper_case <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_signed_decimal();
      test_radix_output();
      test_pointer_output();
      test_unused_mode();
      test_random_items();
      req_if.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/itoa_pkg.sv
sv/itoa_ifs.sv
sv/integer_to_ascii_formatter.sv
test/tb.sv
